>>> rtl/bpmr_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the bad pixel median replacement block
// no dependencies
package bpmr_pkg;

  localparam int FRAME_WIDTH = 160;
  localparam int FRAME_ROWS  = 120;
  localparam int VALUE_BITS  = 24;
  localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = VALUE_BITS + 1;
  // the center is bad, so at most 24 good neighbours
  localparam int NBR_MAX     = 24;
  localparam int CNT_W       = 5;
  localparam int X_W         = 8;
  localparam int Y_W         = 7;
  localparam int CRD_W       = 11;  // signed window coordinate

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_CORRECT = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_CWAIT = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_EVAL  = 8'b0010_0000,
    ST_SEL   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } bpmr_state_t;

  typedef logic signed [VALUE_BITS-1:0] value_t;

endpackage

>>> rtl/bad_pixel_median_replace.sv
`timescale 1ns / 1ps
// bad pixel median replacement: frame store, window gather, sorted insert, median
// depends on bpmr_pkg
// per item: writes and out-of-frame items go straight to the result; a good pixel returns
//   its stored value; a bad pixel searches the 3x3 window, then the 5x5 window if no good
//   neighbour is found, plus median selection when one is; one window read per cycle
// one item in flight; a new request is taken while the last result waits
// reset (synchronous, active low) clears control only; the store is undefined
module bad_pixel_median_replace
  import bpmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_x, pixel_y, pixel_value, bad_flag
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value, neighbour_count, zero pad
  output logic        out_tuser   // replaced
);

  logic [ENTRY_W-1:0] mem [0:STORE_DEPTH-1];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  bpmr_state_t state_r, state_nxt;
  logic             act_r;
  logic [X_W-1:0]   x_r;
  logic [Y_W-1:0]   y_r;
  value_t           val_r;
  logic             bad_r;
  logic [ADDR_W-1:0] caddr_r;
  logic             rad2_r;
  logic signed [2:0] dx_r, dy_r;
  logic             pend_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] k_r;
  value_t           sv_r [0:NBR_MAX-1];
  value_t           lo_r;
  value_t           res_r;
  logic             repl_r;
  logic             out_valid_r;
  value_t           out_val_r;
  logic             out_repl_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic in_acc, out_free, in_frame;
  logic signed [CRD_W-1:0] xx, yy;
  logic win_in, win_last, do_ins;
  logic [ADDR_W-1:0] caddr, waddr;
  logic [NBR_MAX-1:0] gt;
  value_t ins_v;
  value_t sv_nxt [0:NBR_MAX-1];
  logic [CNT_W-1:0] half;
  logic signed [VALUE_BITS:0] msum;
  logic signed [2:0] rad;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign in_frame  = (32'(x_r) < FRAME_WIDTH) && (32'(y_r) < FRAME_ROWS);
  assign caddr     = ADDR_W'(ADDR_W'(y_r) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(x_r);
  assign rad       = rad2_r ? 3'sd2 : 3'sd1;

  assign xx = $signed({3'b000, x_r}) + CRD_W'(dx_r);
  assign yy = $signed({4'b0000, y_r}) + CRD_W'(dy_r);
  assign win_in = (xx >= 0) && (yy >= 0) && (32'(xx) < FRAME_WIDTH)
                  && (32'(yy) < FRAME_ROWS);
  assign waddr = ADDR_W'(ADDR_W'(yy) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(xx);
  assign win_last = (dx_r == rad) && (dy_r == rad);

  // a window read issued last cycle lands now; keep it if the pixel is good
  assign do_ins = pend_r && !rd_data_r[VALUE_BITS]
                  && (state_r == ST_SCAN || state_r == ST_DRAIN);
  assign ins_v  = value_t'(rd_data_r[VALUE_BITS-1:0]);

  // sorted insert: every slot at or past the insert point moves up by one
  always_comb begin
    for (int i = 0; i < NBR_MAX; i++) begin
      gt[i] = !((CNT_W'(i) < cnt_r) && (sv_r[i] <= ins_v));
    end
    for (int i = 0; i < NBR_MAX; i++) begin
      if (!gt[i]) begin
        sv_nxt[i] = sv_r[i];
      end else if (i == 0) begin
        sv_nxt[i] = ins_v;
      end else if (!gt[i-1]) begin
        sv_nxt[i] = ins_v;
      end else begin
        sv_nxt[i] = sv_r[i-1];
      end
    end
  end

  assign half = cnt_r >> 1;
  // lower middle value is held in lo_r, upper middle sits in slot zero
  assign msum = (VALUE_BITS+1)'(lo_r) + (VALUE_BITS+1)'(sv_r[0]);

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = caddr;
    wr_en     = 1'b0;
    wr_addr   = caddr_r;
    wr_data   = {bad_r, val_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_START;
      end
      ST_START: begin
        if (act_r == ACT_WRITE) begin
          wr_en     = in_frame;
          wr_addr   = caddr;
          state_nxt = ST_FIN;
        end else if (!in_frame) begin
          state_nxt = ST_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        state_nxt = rd_data_r[VALUE_BITS] ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        rd_en   = win_in;
        rd_addr = waddr;
        if (win_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (cnt_r != '0) state_nxt = ST_SEL;
        else if (!rad2_r) state_nxt = ST_SCAN;
        else state_nxt = ST_FIN;
      end
      ST_SEL: begin
        if (k_r == half) begin
          wr_en     = 1'b1;
          wr_data   = {1'b1, (cnt_r[0] ? sv_r[0] : value_t'(msum >>> 1))};
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN) && win_in;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser;
      x_r   <= in_tdata[7:0];
      y_r   <= in_tdata[14:8];
      val_r <= value_t'(in_tdata[38:15]);
      bad_r <= in_tdata[39];
    end
    unique case (state_r)
      ST_START: begin
        caddr_r <= caddr;
        repl_r  <= 1'b0;
        cnt_r   <= '0;
        rad2_r  <= 1'b0;
        res_r   <= (act_r == ACT_WRITE) ? val_r : '0;
        dx_r    <= -3'sd1;
        dy_r    <= -3'sd1;
      end
      ST_CWAIT: begin
        res_r  <= value_t'(rd_data_r[VALUE_BITS-1:0]);
      end
      ST_SCAN, ST_DRAIN: begin
        if (state_r == ST_SCAN) begin
          if (dx_r == rad) begin
            dx_r <= -rad;
            dy_r <= dy_r + 3'sd1;
          end else begin
            dx_r <= dx_r + 3'sd1;
          end
        end
        if (do_ins) begin
          sv_r  <= sv_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      ST_EVAL: begin
        k_r <= '0;
        if (cnt_r == '0 && !rad2_r) begin
          rad2_r <= 1'b1;
          dx_r   <= -3'sd2;
          dy_r   <= -3'sd2;
        end
      end
      ST_SEL: begin
        // walk the sorted list down through slot zero
        if (k_r == half - 1'b1) lo_r <= sv_r[0];
        if (k_r == half) begin
          res_r  <= cnt_r[0] ? sv_r[0] : value_t'(msum >>> 1);
          repl_r <= 1'b1;
        end
        for (int i = 0; i < NBR_MAX - 1; i++) sv_r[i] <= sv_r[i+1];
        k_r <= k_r + 1'b1;
      end
      default: ;
    endcase
    if (state_r == ST_FIN && out_free) begin
      out_val_r  <= res_r;
      out_repl_r <= repl_r;
      out_cnt_r  <= repl_r ? cnt_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_val_r};
  assign out_tuser  = out_repl_r;

endmodule

>>> rtl/bpmr_checker.sv
`timescale 1ns / 1ps
// port-level checks for bad_pixel_median_replace, bound to the top level
// depends on bpmr_pkg
module bpmr_checker
  import bpmr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_plain_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[28:24] == 5'd0)
    else $error("count without replacement");

  a_repl_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[28:24] != 5'd0 && out_tdata[28:24] <= 5'(NBR_MAX))
    else $error("replacement count out of range");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

endmodule

bind bad_pixel_median_replace bpmr_checker u_bpmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> bench/bad_pixel_median_replace_tb.sv
`timescale 1ns / 1ps
// self-checking bench for bad_pixel_median_replace: write and correct requests
// are predicted against a local frame copy and compared with every result
// depends on bpmr_pkg and the bad_pixel_median_replace rtl
module bad_pixel_median_replace_tb;
  import bpmr_pkg::*;

  typedef struct {
    logic   act;
    int     px;
    int     py;
    value_t val;
    logic   bad;
  } pixel_req_t;

  typedef struct {
    value_t     value;
    logic       replaced;
    logic [4:0] count;
  } pixel_res_t;

  localparam int RUN_LIMIT = 1000000;
  localparam int N_RANDOM = 985;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;

  bad_pixel_median_replace dut (.*);

  pixel_req_t pending_reqs[$];
  pixel_res_t expected_pixels[$];
  logic [ENTRY_W-1:0] frame_copy [0:STORE_DEPTH-1];
  bit written [0:STORE_DEPTH-1];
  int errors = 0;
  int results_seen = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit in_frame(int x, int y);
    return x >= 0 && y >= 0 && x < FRAME_WIDTH && y < FRAME_ROWS;
  endfunction

  // a correct may read anywhere in its 5x5 window
  function automatic bit window_written(int x, int y);
    for (int dy = -2; dy <= 2; dy++)
      for (int dx = -2; dx <= 2; dx++)
        if (in_frame(x + dx, y + dy) && !written[(y + dy) * FRAME_WIDTH + x + dx])
          return 0;
    return 1;
  endfunction

  // updates the frame copy and queues the expected result of one request
  task automatic issue_pixel(logic act, int x, int y, value_t val, logic bad);
    pixel_req_t r;
    pixel_res_t e;
    longint nbr[25];
    longint t, s;
    int n, idx, j;
    r.act = act; r.px = x; r.py = y; r.val = val; r.bad = bad;
    pending_reqs.insert(pending_reqs.size(), r);
    e.value = '0; e.replaced = 1'b0; e.count = '0;
    if (act == ACT_WRITE) begin
      e.value = val;
      if (in_frame(x, y)) begin
        frame_copy[y * FRAME_WIDTH + x] = {bad, val};
        written[y * FRAME_WIDTH + x] = 1;
      end
    end else if (in_frame(x, y)) begin
      idx = y * FRAME_WIDTH + x;
      e.value = frame_copy[idx][VALUE_BITS-1:0];
      if (frame_copy[idx][VALUE_BITS]) begin
        n = 0;
        for (int rad = 1; rad <= 2 && n == 0; rad++)
          for (int dy = -rad; dy <= rad; dy++)
            for (int dx = -rad; dx <= rad; dx++)
              if (in_frame(x + dx, y + dy) &&
                  !frame_copy[(y + dy) * FRAME_WIDTH + x + dx][VALUE_BITS]) begin
                nbr[n] = value_t'(frame_copy[(y + dy) * FRAME_WIDTH + x + dx][VALUE_BITS-1:0]);
                n++;
              end
        if (n > 0) begin
          for (int i = 1; i < n; i++) begin
            t = nbr[i];
            j = i;
            while (j > 0 && nbr[j-1] > t) begin
              nbr[j] = nbr[j-1];
              j--;
            end
            nbr[j] = t;
          end
          if (n % 2) s = nbr[n/2];
          else s = (nbr[n/2-1] + nbr[n/2]) >>> 1;
          e.value = value_t'(s);
          e.replaced = 1'b1;
          e.count = n[4:0];
          frame_copy[idx] = {1'b1, e.value};
        end
      end
    end
    expected_pixels.insert(expected_pixels.size(), e);
  endtask

  // sender: per-request gap, with bursts of no gaps
  int send_gap = 0;
  bit send_burst = 0;
  always @(posedge clk) begin
    pixel_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tdata <= {r.bad, r.val, r.py[6:0], r.px[7:0]};
        in_tuser <= r.act;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        send_gap <= send_burst ? 0 : $urandom_range(0, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: per-result stall, one long hold-off to back up the input
  int recv_hold = 0;
  bit recv_burst = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (out_tvalid && out_tready) begin
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1;
        out_tready <= 1'b0;
        recv_hold <= 400;
      end else begin
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        if (recv_burst) begin
          out_tready <= 1'b1;
        end else begin
          recv_hold <= $urandom_range(0, 14);
          out_tready <= 1'b0;
        end
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  // checker
  always @(posedge clk) begin
    pixel_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (out_tdata[23:0] !== e.value) begin
          $error("result_value expected %0d got %0d", e.value, $signed(out_tdata[23:0]));
          errors++;
        end
        if (out_tuser !== e.replaced) begin
          $error("replaced expected %0d got %0d", e.replaced, out_tuser);
          errors++;
        end
        if (out_tdata[28:24] !== e.count) begin
          $error("neighbour_count expected %0d got %0d", e.count, out_tdata[28:24]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  int patch_x[5] = '{0, 152, 0, 152, 76};
  int patch_y[5] = '{0, 0, 112, 112, 56};

  initial begin
    int p, x, y, bad_pct;
    // out-of-frame requests touch no memory
    issue_pixel(ACT_WRITE, 255, 127, 24'h7FFFFF, 1'b1);
    issue_pixel(ACT_WRITE, 160, 0, 24'h800000, 1'b0);
    issue_pixel(ACT_CORRECT, 160, 0, '0, 1'b0);
    issue_pixel(ACT_CORRECT, 0, 120, '1, 1'b1);
    issue_pixel(ACT_CORRECT, 255, 127, '0, 1'b0);
    // fill five 8x8 patches so every later read hits written pixels
    for (int k = 0; k < 5; k++)
      for (int i = 0; i < 64; i++)
        issue_pixel(ACT_WRITE, patch_x[k] + i % 8, patch_y[k] + i / 8,
                    value_t'($urandom()), $urandom_range(0, 3) == 0);
    issue_pixel(ACT_WRITE, 5, 5, 24'h000123, 1'b0);
    issue_pixel(ACT_CORRECT, 5, 5, '0, 1'b0);   // good pixel
    // even count with extreme values: min, min, max, max
    issue_pixel(ACT_WRITE, 2, 0, 24'h7FFFFF, 1'b0);
    issue_pixel(ACT_WRITE, 4, 0, 24'h7FFFFF, 1'b0);
    issue_pixel(ACT_WRITE, 2, 1, 24'h000000, 1'b1);
    issue_pixel(ACT_WRITE, 3, 1, 24'h800000, 1'b0);
    issue_pixel(ACT_WRITE, 4, 1, 24'h800000, 1'b0);
    issue_pixel(ACT_WRITE, 3, 0, 24'h000001, 1'b1);
    issue_pixel(ACT_CORRECT, 3, 0, '0, 1'b0);
    // corner: 3x3 all bad forces the 5x5 search, then nothing good at all
    issue_pixel(ACT_WRITE, 0, 0, 24'h000010, 1'b1);
    issue_pixel(ACT_WRITE, 1, 0, 24'h000020, 1'b1);
    issue_pixel(ACT_WRITE, 0, 1, 24'h000030, 1'b1);
    issue_pixel(ACT_WRITE, 1, 1, 24'h000040, 1'b1);
    issue_pixel(ACT_CORRECT, 0, 0, '0, 1'b0);
    for (int i = 0; i < 25; i++)
      issue_pixel(ACT_WRITE, i % 5, i / 5, value_t'($urandom()), 1'b1);
    issue_pixel(ACT_CORRECT, 2, 2, '0, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      bad_pct = ((i / 300) % 2) ? 85 : 20;
      p = $urandom_range(0, 4);
      x = patch_x[p] + $urandom_range(0, 7);
      y = patch_y[p] + $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) x = $urandom_range(FRAME_WIDTH, 255);
        else y = $urandom_range(FRAME_ROWS, 127);
      end
      if ($urandom_range(0, 1) && (!in_frame(x, y) || window_written(x, y)))
        issue_pixel(ACT_CORRECT, x, y, value_t'($urandom()), $urandom_range(0, 1));
      else
        issue_pixel(ACT_WRITE, x, y, value_t'($urandom()),
                    $urandom_range(0, 99) < bad_pct);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
